// ===== sv/cell_ref_pilot_mapper_defines.svh =====
// Assertion macros for the cell reference pilot mapper.
// Users must have signals named clock and reset in scope.
`ifndef CELL_REF_PILOT_MAPPER_DEFINES_SVH
`define CELL_REF_PILOT_MAPPER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CREF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CREF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cref_pkg.sv =====
// Shared types and constants for the cell reference pilot mapper.
// No dependencies; used by cref_cfg and cell_ref_pilot_mapper.
package cref_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_RB     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_SHIFT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FFT_SIZE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE  = 3'd4;

   localparam int MIN_RB        = 6;
   localparam int RESET_RB      = 50;
   localparam int RESET_FFT     = 512;
   localparam int RESET_AMP     = 23170;
   localparam int INV_SQRT2_Q15 = 23170;
   localparam logic [14:0] AMP_RESET_Q = 15'((RESET_AMP * INV_SQRT2_Q15) >> 15);

   localparam logic [3:0] PAIR_LAST   = 4'hF;
   localparam logic [2:0] SHIFT_ALT   = 3'd3;
   localparam logic [3:0] SHIFT_MOD   = 4'd6;
   localparam logic [3:0] SHIFT_MAX   = 4'd5;
   localparam logic [12:0] SC_STEP    = 13'd6;

   typedef struct packed {
      logic [31:0] gold_word;
      logic [3:0]  word_index;
      logic [1:0]  antenna_port;
      logic        first_in_slot;
   } req_type;

   typedef struct packed {
      logic [11:0]        subcarrier;
      logic signed [15:0] pilot_re;
      logic signed [15:0] pilot_im;
      logic               last_of_word;
      logic               last_of_symbol;
      logic               error;
   } rsp_type;

   // derived configuration handed from the register block to the datapath
   typedef struct packed {
      logic [7:0]  win_lo;
      logic [7:0]  win_hi;
      logic [2:0]  cell_shift;
      logic [10:0] carrier_offset;
      logic [11:0] fft_size;
      logic [14:0] amp_q;
   } cfg_type;

endpackage

// ===== sv/cref_cfg.sv =====
// Configuration registers for the pilot mapper; derives window bounds
// and the scaled amplitude at write time. Depends on cref_pkg.
module cref_cfg #(
   parameter int MAX_RB = 110
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cref_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cref_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output cref_pkg::cfg_type                cfg
);
   import cref_pkg::*;

   localparam int RstRb = (RESET_RB > MAX_RB) ? MAX_RB : RESET_RB;
   localparam logic [6:0] MaxRb = 7'(MAX_RB);
   localparam logic [6:0] MinRb = 7'(MIN_RB);
   localparam logic [7:0] MaxRb8 = 8'(MAX_RB);
   localparam logic [7:0] MaxRbM1 = 8'(MAX_RB - 1);
   localparam logic [14:0] InvSqrt2 = 15'(INV_SQRT2_Q15);

   cfg_type    cfg_ff, cfg_in;
   logic [6:0] nrb;
   logic [29:0] amp_prod;

   assign csr_ready = 1'b1;

   always_comb begin
      nrb = csr_wdata[6:0];
      if (nrb < MinRb) begin
         nrb = MinRb;
      end else if (nrb > MaxRb) begin
         nrb = MaxRb;
      end
      amp_prod = 30'(csr_wdata[14:0]) * 30'(InvSqrt2);
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_RB: begin
               cfg_in.win_lo = MaxRb8 - {1'b0, nrb};
               cfg_in.win_hi = MaxRbM1 + {1'b0, nrb};
            end
            CSR_CELL_SHIFT: cfg_in.cell_shift     = csr_wdata[2:0];
            CSR_CARRIER:    cfg_in.carrier_offset = csr_wdata[10:0];
            CSR_FFT_SIZE:   cfg_in.fft_size       = csr_wdata[11:0];
            CSR_AMPLITUDE:  cfg_in.amp_q          = amp_prod[29:15];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_lo         <= 8'(MAX_RB - RstRb);
         cfg_ff.win_hi         <= 8'(MAX_RB - 1 + RstRb);
         cfg_ff.cell_shift     <= '0;
         cfg_ff.carrier_offset <= '0;
         cfg_ff.fft_size       <= 12'(RESET_FFT);
         cfg_ff.amp_q          <= AMP_RESET_Q;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/cell_ref_pilot_mapper.sv =====
// Top level of the downlink cell reference pilot mapper: pair-serial
// sequencer and output register. Depends on cref_pkg, cref_cfg and the defines.
//
// Usage:
//  - req channel (req_valid/req_stall/req_data): one beat per Gold word of a
//    symbol, words in increasing word_index order.
//  - rsp channel (rsp_valid/rsp_stall/rsp_data): one beat per pilot, up to
//    sixteen per word; last_of_word marks the final beat of a word,
//    last_of_symbol the final pilot of the window.
//  - csr channel (csr_valid/csr_ready/csr_index/csr_wdata): always ready,
//    not gated; the user must write registers only while no word is in flight.
//  - A word's 32 bits sit in a shift register that drops one bit pair per
//    cycle unless rsp_stall holds it; each such cycle checks one pilot index
//    against the window until the last pair (a bad port gives one error beat).
//  - The next word is accepted in the cycle of the last pair.
//  - Each pilot is registered in the output register as its pair is checked.
//  - rsp_stall freezes the sequencer while the output register is full; the
//    held beat stays unchanged.
//  - Reset (synchronous): drops all beats in flight, clears the running
//    subcarrier and restores the register defaults.
module cell_ref_pilot_mapper #(
   parameter int MAX_RB = 110
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cref_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cref_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cref_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cref_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cref_pkg::*;
   `include "cell_ref_pilot_mapper_defines.svh"

   cfg_type cfg;

   cref_cfg #(.MAX_RB(MAX_RB)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer state
   logic        busy_ff, busy_in;
   logic        err_ff, err_in;
   logic [3:0]  pair_ff, pair_in;      // bit pair position in the word
   logic [7:0]  mp_ff, mp_in;          // pilot index of current pair
   logic [31:0] gold_ff, gold_in;      // pairs shift out at the bottom
   logic [11:0] start_ff, start_in;    // subcarrier of the window's first pilot
   logic [11:0] next_sc_ff, next_sc_in;
   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept, adv, last_step, hit;
   logic [11:0] sc_k, sc_step;
   logic [12:0] sc_t;
   logic [3:0]  shift_sum;
   logic [2:0]  nu;
   logic [15:0] pos_a, neg_a;

   assign adv       = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_step = err_ff || (pair_ff == PAIR_LAST);
   // a new word may enter in the same cycle the last pair leaves
   assign req_stall = busy_ff && !(adv && last_step);
   assign accept    = req_valid && !req_stall;

   assign hit  = !err_ff && (mp_ff >= cfg.win_lo) && (mp_ff <= cfg.win_hi);
   assign sc_k = (mp_ff == cfg.win_lo) ? start_ff : next_sc_ff;

   // next subcarrier: +6, wrap past fft size skipping DC
   always_comb begin
      sc_t = {1'b0, sc_k} + SC_STEP;
      if (sc_t >= {1'b0, cfg.fft_size}) begin
         sc_t = sc_t + 13'd1 - {1'b0, cfg.fft_size};
      end
      sc_step = sc_t[11:0];
   end

   assign pos_a = {1'b0, cfg.amp_q};
   assign neg_a = 16'd0 - pos_a;

   // start subcarrier of the symbol from port/symbol shift
   always_comb begin
      nu = ((req_data.antenna_port == 2'd0) == req_data.first_in_slot) ? 3'd0 : SHIFT_ALT;
      shift_sum = {1'b0, nu} + {1'b0, cfg.cell_shift};
      if (shift_sum > SHIFT_MAX) begin
         shift_sum = shift_sum - SHIFT_MOD;
      end
      start_in = {8'd0, shift_sum} + {1'b0, cfg.carrier_offset};
   end

   always_comb begin
      busy_in      = busy_ff;
      err_in       = err_ff;
      pair_in      = pair_ff;
      mp_in        = mp_ff;
      gold_in      = gold_ff;
      next_sc_in   = next_sc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (adv) begin
         pair_in = pair_ff + 4'd1;
         mp_in   = mp_ff + 8'd1;
         gold_in = {2'b00, gold_ff[31:2]};
         if (last_step) begin
            busy_in = 1'b0;
         end
         if (err_ff) begin
            rsp_in.subcarrier     = '0;
            rsp_in.pilot_re       = '0;
            rsp_in.pilot_im       = '0;
            rsp_in.last_of_word   = 1'b1;
            rsp_in.last_of_symbol = 1'b0;
            rsp_in.error          = 1'b1;
            rsp_valid_in          = 1'b1;
         end else if (hit) begin
            rsp_in.subcarrier     = sc_k;
            rsp_in.pilot_re       = gold_ff[0] ? neg_a : pos_a;
            rsp_in.pilot_im       = gold_ff[1] ? neg_a : pos_a;
            rsp_in.last_of_word   = (pair_ff == PAIR_LAST) || (mp_ff == cfg.win_hi);
            rsp_in.last_of_symbol = (mp_ff == cfg.win_hi);
            rsp_in.error          = 1'b0;
            rsp_valid_in          = 1'b1;
            next_sc_in            = sc_step;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         err_in  = req_data.antenna_port[1];
         pair_in = '0;
         mp_in   = {req_data.word_index, 4'd0};
         gold_in = req_data.gold_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         err_ff       <= 1'b0;
         pair_ff      <= '0;
         next_sc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         err_ff       <= err_in;
         pair_ff      <= pair_in;
         next_sc_ff   <= next_sc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mp_ff   <= mp_in;
      gold_ff <= gold_in;
      rsp_ff  <= rsp_in;
      if (accept) begin
         start_ff <= start_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CREF_ASSERT_NXT(a_accept_starts, accept, busy_ff && (pair_ff == 4'd0), "accept did not start sequencer")
   `CREF_ASSERT_IMP(a_sym_end_word_end, rsp_valid && rsp_data.last_of_symbol, rsp_data.last_of_word, "symbol end without word end")
   `CREF_ASSERT_IMP(a_error_beat_clean, rsp_valid && rsp_data.error, (rsp_data.subcarrier == 12'd0) && (rsp_data.pilot_re == 16'sd0) && (rsp_data.pilot_im == 16'sd0) && rsp_data.last_of_word && !rsp_data.last_of_symbol, "error beat carries data")

endmodule
